FILE: src/mcsh_pkg.sv
// Package: shared constants, types and functions for the masked codeword SHA-1 block.
package mcsh_pkg;

  localparam int unsigned LaneWords = 14;
  localparam int unsigned LaneW     = 5;
  localparam int unsigned WordW     = 64;
  localparam int unsigned QDepth    = 2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  // Classified work handed from front to back.
  typedef struct packed {
    logic [WordW-1:0] code;
    logic             last;
  } lane_t;

  typedef struct packed {
    logic [WordW-1:0] digest_low;
    logic [WordW-1:0] digest_high;
  } digest_t;

  // Byte-reverse a 64-bit word.
  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*(7-i) +: 8] = x[8*i +: 8];
    end
    return r;
  endfunction

  // Byte-reverse a 32-bit word.
  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

FILE: src/mcsh_if.sv
// Interfaces: valid/ready channels for input items and digest results.
interface mcsh_in_if (input logic clk_i);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [mcsh_pkg::LaneW-1:0]    lane;
  logic [mcsh_pkg::WordW-1:0]    t_word;
  logic [mcsh_pkg::WordW-1:0]    correction_word;
  logic [mcsh_pkg::WordW-1:0]    input_word;
  logic [mcsh_pkg::WordW-1:0]    choice_word;
  logic                          last;
  modport source (output valid, mode, lane, t_word, correction_word, input_word,
                  choice_word, last, input ready);
  modport sink (input valid, mode, lane, t_word, correction_word, input_word,
                choice_word, last, output ready);
endinterface

interface mcsh_out_if (input logic clk_i);
  logic                       valid;
  logic                       ready;
  logic [mcsh_pkg::WordW-1:0] digest_low;
  logic [mcsh_pkg::WordW-1:0] digest_high;
  modport source (output valid, digest_low, digest_high, input ready);
  modport sink (input valid, digest_low, digest_high, output ready);
endinterface

FILE: src/masked_codeword_sha1_hash_top.sv
// Top level: front end, lane queue and SHA-1 back end.
// A load beat is taken whenever the lane queue has room. An encode beat is masked
// and pushed into the queue as it is accepted; the back end absorbs a lane while
// idle, and every eighth lane runs a compression on the single-round SHA-1 engine.
// A last lane adds one or two further compressions for padding and length, each
// set up in its own state, and then a state that loads the digest.
// The digest sits in an output register; while it is full the back end takes no lane.
module masked_codeword_sha1_hash_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcsh_in_if.sink    in_i,
  mcsh_out_if.source out_o
);

  logic            push, full, pop, empty;
  mcsh_pkg::lane_t push_data, pop_data;

  mcsh_front u_front (
    .clk_i, .in_i, .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  mcsh_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  mcsh_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .lane_i(pop_data), .pop_o(pop), .out_o
  );

endmodule

FILE: src/mcsh_front.sv
// Front end: choice store, lane filter and masking of encode beats.
module mcsh_front (
  input  logic                  clk_i,
  mcsh_in_if.sink               in_i,
  output logic                  push_o,
  output mcsh_pkg::lane_t       push_data_o,
  input  logic                  full_i
);

  logic [mcsh_pkg::WordW-1:0] choice_q [mcsh_pkg::LaneWords];
  logic                       in_range;
  logic                       acc;
  logic [$clog2(mcsh_pkg::LaneWords)-1:0] idx;

  assign in_range = (in_i.lane < mcsh_pkg::LaneW'(mcsh_pkg::LaneWords));
  assign idx      = in_i.lane[$clog2(mcsh_pkg::LaneWords)-1:0];
  // Every beat, load or encode, waits for queue room.
  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;

  // Write choice words.
  always_ff @(posedge clk_i) begin
    if (acc && !in_i.mode && in_range) begin
      choice_q[idx] <= in_i.choice_word;
    end
  end

  // Mask the encode beat and push it.
  always_comb begin
    push_o           = acc && in_i.mode && in_range;
    push_data_o.last = in_i.last;
    push_data_o.code = '0;
    if (in_range) begin
      push_data_o.code = in_i.t_word ^ ((in_i.correction_word ^ in_i.input_word)
                         & choice_q[idx]);
    end
  end

endmodule

FILE: src/mcsh_queue.sv
// Short FIFO between front end and hash engine.
module mcsh_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcsh_pkg::lane_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mcsh_pkg::lane_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(mcsh_pkg::QDepth);

  mcsh_pkg::lane_t     mem_q [mcsh_pkg::QDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  logic                do_pop, do_push;

  assign full_o     = (cnt_q == (PtrW+1)'(mcsh_pkg::QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/mcsh_back.sv
// Back end: message buffer, SHA-1 round engine, padding and digest register.
module mcsh_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  mcsh_pkg::lane_t lane_i,
  output logic            pop_o,
  mcsh_out_if.source      out_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRnd  = 3'd1;
  localparam logic [2:0] StPad  = 3'd2;
  localparam logic [2:0] StLen  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [63:0] buf_q [8];
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  rnd_q;
  logic [7:0]  bc_q;
  logic [2:0]  next_q;  // state after compression
  logic        ovalid_q;
  logic [63:0] olo_q, ohi_q;

  logic [31:0] f, k, tmp, wn;
  logic [2:0]  pos;
  logic [63:0] bitlen;

  assign pos    = bc_q[5:3];
  assign bitlen = {53'd0, bc_q, 3'd0};
  assign pop_o  = (st_q == StIdle) && !empty_i && !ovalid_q;

  // Round function.
  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    wn  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wn  = {wn[30:0], wn[31]};
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  st_d = st_q;
      StRnd:   st_d = st_q;
      StPad:   st_d = st_q;
      StLen:   st_d = st_q;
      StOut:   st_d = st_q;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      rnd_q    <= '0;
      bc_q     <= '0;
      next_q   <= StIdle;
      ovalid_q <= 1'b0;
      h_q[0] <= mcsh_pkg::H0; h_q[1] <= mcsh_pkg::H1; h_q[2] <= mcsh_pkg::H2;
      h_q[3] <= mcsh_pkg::H3; h_q[4] <= mcsh_pkg::H4;
    end else begin
      if (ovalid_q && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (st_d)
        StIdle: begin
          if (pop_o) begin
            buf_q[pos] <= lane_i.code;
            bc_q       <= bc_q + 8'd8;
            if (pos == 3'd7) begin
              st_q   <= StRnd;
              rnd_q  <= '0;
              next_q <= lane_i.last ? StPad : StIdle;
              for (int i = 0; i < 7; i++) begin
                w_q[2*i]   <= mcsh_pkg::bswap32(buf_q[i][31:0]);
                w_q[2*i+1] <= mcsh_pkg::bswap32(buf_q[i][63:32]);
              end
              w_q[14] <= mcsh_pkg::bswap32(lane_i.code[31:0]);
              w_q[15] <= mcsh_pkg::bswap32(lane_i.code[63:32]);
              a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
              d_q <= h_q[3]; e_q <= h_q[4];
            end else if (lane_i.last) begin
              st_q <= StPad;
            end
          end
        end
        StRnd: begin
          e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= tmp;
          for (int i = 0; i < 15; i++) begin
            w_q[i] <= w_q[i+1];
          end
          w_q[15] <= wn;
          if (rnd_q == 7'd79) begin
            h_q[0] <= h_q[0] + tmp; h_q[1] <= h_q[1] + a_q;
            h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
            h_q[3] <= h_q[3] + c_q; h_q[4] <= h_q[4] + d_q;
            st_q   <= next_q;
          end
          rnd_q <= rnd_q + 7'd1;
        end
        StPad: begin
          // Place the end marker, then either compress a full block or add length.
          rnd_q <= '0;
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          if (pos == 3'd7) begin
            for (int i = 0; i < 7; i++) begin
              w_q[2*i]   <= mcsh_pkg::bswap32(buf_q[i][31:0]);
              w_q[2*i+1] <= mcsh_pkg::bswap32(buf_q[i][63:32]);
            end
            w_q[14] <= 32'h80000000;
            w_q[15] <= '0;
            for (int i = 0; i < 8; i++) begin
              buf_q[i] <= '0;
            end
            st_q   <= StRnd;
            next_q <= StLen;
          end else begin
            for (int i = 0; i < 7; i++) begin
              if (3'(i) == pos) begin
                w_q[2*i]   <= 32'h80000000;
                w_q[2*i+1] <= '0;
              end else if (3'(i) > pos) begin
                w_q[2*i]   <= '0;
                w_q[2*i+1] <= '0;
              end else begin
                w_q[2*i]   <= mcsh_pkg::bswap32(buf_q[i][31:0]);
                w_q[2*i+1] <= mcsh_pkg::bswap32(buf_q[i][63:32]);
              end
            end
            w_q[14] <= bitlen[63:32];
            w_q[15] <= bitlen[31:0];
            st_q    <= StRnd;
            next_q  <= StOut;
          end
        end
        StLen: begin
          rnd_q <= '0;
          a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          for (int i = 0; i < 14; i++) begin
            w_q[i] <= '0;
          end
          w_q[14] <= bitlen[63:32];
          w_q[15] <= bitlen[31:0];
          st_q    <= StRnd;
          next_q  <= StOut;
        end
        StOut: begin
          // Hold until the digest register is free, then restart the chain.
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            olo_q    <= {mcsh_pkg::bswap32(h_q[1]), mcsh_pkg::bswap32(h_q[0])};
            ohi_q    <= {mcsh_pkg::bswap32(h_q[3]), mcsh_pkg::bswap32(h_q[2])};
            h_q[0] <= mcsh_pkg::H0; h_q[1] <= mcsh_pkg::H1; h_q[2] <= mcsh_pkg::H2;
            h_q[3] <= mcsh_pkg::H3; h_q[4] <= mcsh_pkg::H4;
            bc_q   <= '0;
            st_q   <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.digest_low  = olo_q;
  assign out_o.digest_high = ohi_q;

endmodule
